// File: src/clm_pkg.sv
package clm_pkg;

    localparam int DATA_W   = 63;
    localparam int LEN_W    = 32;
    localparam int FB_W     = 5;
    localparam int WIDX_W   = 27;
    localparam int MAX_RUNS = 16;
    localparam int NRUN_W   = $clog2(MAX_RUNS + 1);
    localparam int PTR_W    = $clog2(MAX_RUNS);
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        KIND_DENSE = 2'd0,
        KIND_NIL   = 2'd1,
        KIND_EXCL  = 2'd2,
        KIND_MASK  = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KIND        = 2'd0,
        REG_START_VALUE = 2'd1,
        REG_TOTAL_COUNT = 2'd2,
        REG_FIRST_BIT   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0] first;
        logic [LEN_W-1:0]  len;
        logic              nil;
    } run_t;

endpackage

// File: src/candidate_list_materializer.sv
// flow: a request sits in the input register right after the edge that accepts it, and its
// runs are registered into the run buffer, and so put on the outputs, once that buffer is
// free, which a stall downstream can delay
// throughput: one request per cycle while each gives at most one run and out_stall is low; a
// request with n runs holds the run buffer until all n leave, one run per cycle without stall
// reset: asynchronous, active low; clears configuration, list state and handshake registers
module candidate_list_materializer
    import clm_pkg::*;
#(
    parameter int MASK_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    // request channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [DATA_W-1:0]    data_word,
    input  logic                 last,
    // run channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [DATA_W-1:0]    run_first,
    output logic [LEN_W-1:0]     run_length,
    output logic                 run_nil,
    output logic                 run_last
);

    localparam int CW = $clog2(MASK_BITS + 1);
    localparam int OW = $clog2(MASK_BITS);

    // configuration registers
    kind_t               kind_reg;
    logic [DATA_W-1:0]   start_reg;
    logic [LEN_W-1:0]    total_reg;
    logic [FB_W-1:0]     first_bit_reg;

    // list state
    logic [DATA_W-1:0]   next_value_reg, next_value_next;
    logic [LEN_W-1:0]    emitted_reg, emitted_next;
    logic [WIDX_W-1:0]   word_index_reg, word_index_next;
    logic [DATA_W-1:0]   base_reg, base_next;
    logic                stuck_reg, stuck_next;
    logic                finished_reg, finished_next;

    // input register
    logic                in_full_reg;
    logic [DATA_W-1:0]   in_word_reg;
    logic                in_last_reg;

    // run buffer, drained one run per cycle while out_stall is low
    run_t                burst_reg [MAX_RUNS];
    logic [NRUN_W-1:0]   left_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;

    logic                out_take;
    logic                burst_free;
    logic                move;
    logic                in_take;

    run_t                runs_new [MAX_RUNS];
    logic [NRUN_W-1:0]   n_new;
    logic [LEN_W-1:0]    rem;

    // exclusion path
    logic                ex_ge;
    logic [DATA_W-1:0]   gap;
    logic [LEN_W-1:0]    ex_len;
    logic [LEN_W-1:0]    rem_after;
    logic [DATA_W-1:0]   nv_after;
    logic                ex_run;
    logic [LEN_W-1:0]    fl_rem;
    logic [DATA_W-1:0]   fl_nv;

    // mask path
    logic [MASK_BITS+DATA_W-1:0] wide_word;
    logic [MASK_BITS-1:0] mw;
    logic [MASK_BITS-1:0] st;
    logic [MASK_BITS-1:0] lowm;
    logic [MASK_BITS-1:0] counted;
    logic [CW-1:0]        pre_ones  [MASK_BITS];
    logic [CW-1:0]        start_cnt [MASK_BITS];
    logic [MASK_BITS-1:0] sel;
    logic [OW-1:0]        off;
    logic                 sv;
    logic [CW-1:0]        mslot_len [MAX_RUNS];
    logic [OW-1:0]        mslot_off [MAX_RUNS];
    logic [MAX_RUNS-1:0]  mslot_valid;
    logic [CW-1:0]        mask_total;
    logic [NRUN_W-1:0]    mask_n;

    logic [DATA_W-1:0]    cfg_start;
    logic [FB_W-1:0]      cfg_fb;

    // handshake: the run buffer frees when empty or when its final run leaves now
    assign out_valid  = (left_reg != '0);
    assign out_take   = out_valid && !out_stall;
    assign burst_free = (left_reg == '0) || ((left_reg == NRUN_W'(1)) && out_take);
    assign move       = in_full_reg && burst_free;
    assign in_stall   = in_full_reg && !burst_free;
    assign in_take    = in_valid && !in_stall;

    // identifiers still allowed for this list
    assign rem = (emitted_reg < total_reg) ? (total_reg - emitted_reg) : '0;

    // exclusion: run up to the excluded value, capped by what is left
    assign ex_ge     = (in_word_reg >= next_value_reg);
    assign gap       = in_word_reg - next_value_reg;
    assign ex_len    = (gap < DATA_W'(rem)) ? gap[LEN_W-1:0] : rem;
    assign rem_after = rem - ex_len;
    assign nv_after  = (DATA_W'(ex_len) == gap) ? (in_word_reg + DATA_W'(1))
                                                : (next_value_reg + DATA_W'(ex_len));
    assign ex_run    = !stuck_reg && ex_ge && (ex_len != '0);
    assign fl_rem    = (!stuck_reg && ex_ge) ? rem_after : rem;
    assign fl_nv     = (!stuck_reg && ex_ge) ? nv_after : next_value_reg;

    // mask: every bit works out its own prefix counts, so the groups come out in parallel
    assign wide_word = {{MASK_BITS{1'b0}}, in_word_reg};
    assign mw        = wide_word[MASK_BITS-1:0];
    assign st        = mw & ~(mw << 1);

    always_comb
    begin
        lowm = '0;
        for (int i = 0; i < MASK_BITS; i++)
        begin
            // ones strictly below bit i
            lowm = {MASK_BITS{1'b1}} >> (MASK_BITS - i);
            pre_ones[i] = CW'($countones(mw & lowm));
            // group starts at or below bit i, the group number of a set bit
            lowm = {MASK_BITS{1'b1}} >> (MASK_BITS - 1 - i);
            start_cnt[i] = CW'($countones(st & lowm));
            counted[i] = mw[i] && (32'(pre_ones[i]) < 32'(rem))
                         && (32'(start_cnt[i]) <= 32'(MAX_RUNS));
        end
    end

    always_comb
    begin
        sel = '0;
        off = '0;
        sv  = 1'b0;
        for (int k = 0; k < MAX_RUNS; k++)
        begin
            sel = '0;
            off = '0;
            sv  = 1'b0;
            for (int i = 0; i < MASK_BITS; i++)
            begin
                if (32'(start_cnt[i]) == 32'(k + 1))
                begin
                    sel[i] = counted[i];
                    if (st[i])
                    begin
                        off = OW'(i);
                        sv  = counted[i];
                    end
                end
            end
            mslot_len[k]   = CW'($countones(sel));
            mslot_off[k]   = off;
            mslot_valid[k] = sv;
        end
    end

    assign mask_total = CW'($countones(counted));
    assign mask_n     = NRUN_W'($countones(mslot_valid));

    // runs and next list state for the request in the input register
    always_comb
    begin
        for (int k = 0; k < MAX_RUNS; k++)
        begin
            runs_new[k] = '0;
        end
        n_new           = '0;
        next_value_next = next_value_reg;
        emitted_next    = emitted_reg;
        word_index_next = word_index_reg;
        base_next       = base_reg;
        stuck_next      = stuck_reg;
        finished_next   = finished_reg;

        if (!finished_reg)
        begin
            unique case (kind_reg)
                KIND_DENSE, KIND_NIL:
                begin
                    if (rem != '0)
                    begin
                        runs_new[0].first = (kind_reg == KIND_NIL) ? '0 : next_value_reg;
                        runs_new[0].len   = rem;
                        runs_new[0].nil   = (kind_reg == KIND_NIL);
                        n_new = NRUN_W'(1);
                    end
                    emitted_next  = total_reg;
                    finished_next = 1'b1;
                end
                KIND_EXCL:
                begin
                    if (!stuck_reg)
                    begin
                        if (!ex_ge)
                        begin
                            // value below the cursor: ignore all further exclusions
                            stuck_next = 1'b1;
                        end
                        else
                        begin
                            emitted_next    = emitted_reg + ex_len;
                            next_value_next = nv_after;
                        end
                    end
                    if (ex_run)
                    begin
                        runs_new[0].first = next_value_reg;
                        runs_new[0].len   = ex_len;
                        runs_new[0].nil   = 1'b0;
                        n_new = NRUN_W'(1);
                    end
                    if (in_last_reg)
                    begin
                        // flush what is left after the last exclusion
                        if (fl_rem != '0)
                        begin
                            if (ex_run)
                            begin
                                runs_new[1].first = fl_nv;
                                runs_new[1].len   = fl_rem;
                                runs_new[1].nil   = 1'b0;
                                n_new = NRUN_W'(2);
                            end
                            else
                            begin
                                runs_new[0].first = fl_nv;
                                runs_new[0].len   = fl_rem;
                                runs_new[0].nil   = 1'b0;
                                n_new = NRUN_W'(1);
                            end
                        end
                        emitted_next  = total_reg;
                        finished_next = 1'b1;
                    end
                end
                KIND_MASK:
                begin
                    for (int k = 0; k < MAX_RUNS; k++)
                    begin
                        runs_new[k].first = base_reg + DATA_W'(mslot_off[k]);
                        runs_new[k].len   = LEN_W'(mslot_len[k]);
                        runs_new[k].nil   = 1'b0;
                    end
                    n_new        = mask_n;
                    emitted_next = emitted_reg + LEN_W'(mask_total);
                    // word base follows the 27-bit word counter, wrapping with it
                    word_index_next = word_index_reg + WIDX_W'(1);
                    if (word_index_reg == {WIDX_W{1'b1}})
                    begin
                        base_next = start_reg - DATA_W'(first_bit_reg);
                    end
                    else
                    begin
                        base_next = base_reg + DATA_W'(MASK_BITS);
                    end
                    if (in_last_reg)
                    begin
                        finished_next = 1'b1;
                    end
                end
                default:
                begin
                    finished_next = finished_reg;
                end
            endcase
        end
    end

    // start value and first bit as they stand after a configuration write
    assign cfg_start = (cfg_idx_t'(cfg_index) == REG_START_VALUE) ? cfg_data : start_reg;
    assign cfg_fb    = (cfg_idx_t'(cfg_index) == REG_FIRST_BIT) ? cfg_data[FB_W-1:0]
                                                                 : first_bit_reg;

    // configuration and list state; any register write restarts the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg       <= KIND_DENSE;
            start_reg      <= '0;
            total_reg      <= '0;
            first_bit_reg  <= '0;
            next_value_reg <= '0;
            emitted_reg    <= '0;
            word_index_reg <= '0;
            base_reg       <= '0;
            stuck_reg      <= 1'b0;
            finished_reg   <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_KIND:        kind_reg      <= kind_t'(cfg_data[1:0]);
                REG_START_VALUE: start_reg     <= cfg_data;
                REG_TOTAL_COUNT: total_reg     <= cfg_data[LEN_W-1:0];
                REG_FIRST_BIT:   first_bit_reg <= cfg_data[FB_W-1:0];
                default:         kind_reg      <= kind_reg;
            endcase
            next_value_reg <= cfg_start;
            emitted_reg    <= '0;
            word_index_reg <= '0;
            base_reg       <= cfg_start - DATA_W'(cfg_fb);
            stuck_reg      <= 1'b0;
            finished_reg   <= 1'b0;
        end
        else if (move)
        begin
            next_value_reg <= next_value_next;
            emitted_reg    <= emitted_next;
            word_index_reg <= word_index_next;
            base_reg       <= base_next;
            stuck_reg      <= stuck_next;
            finished_reg   <= finished_next;
        end
    end

    // control of the input register and the run buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            left_reg    <= '0;
            rd_ptr_reg  <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_full_reg <= 1'b1;
            end
            else if (move)
            begin
                in_full_reg <= 1'b0;
            end

            if (move)
            begin
                left_reg   <= n_new;
                rd_ptr_reg <= '0;
            end
            else if (out_take)
            begin
                left_reg   <= left_reg - NRUN_W'(1);
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_word_reg <= data_word;
            in_last_reg <= last;
        end
        if (move)
        begin
            for (int k = 0; k < MAX_RUNS; k++)
            begin
                burst_reg[k] <= runs_new[k];
            end
        end
    end

    // current run on the outputs; the last run of a request carries run_last
    assign run_first  = burst_reg[rd_ptr_reg].first;
    assign run_length = burst_reg[rd_ptr_reg].len;
    assign run_nil    = burst_reg[rd_ptr_reg].nil;
    assign run_last   = (left_reg == NRUN_W'(1));

endmodule
